[rtl/core/piecewise_stress_strain_eval_unit_assert.svh]
// Assertion macros for the piecewise stress-strain evaluator.
`ifndef PIECEWISE_STRESS_STRAIN_EVAL_UNIT_ASSERT_SVH
`define PIECEWISE_STRESS_STRAIN_EVAL_UNIT_ASSERT_SVH

// Checked only outside reset.
`define PSSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PSSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/psse_pkg.sv]
// Types, codes and helper functions shared by the stress-strain evaluator.
`default_nettype none
package psse_pkg;

  localparam logic CMD_EVAL = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [2:0] REG_YOUNGS   = 3'd0;
  localparam logic [2:0] REG_POISSON  = 3'd1;
  localparam logic [2:0] REG_LINEAR   = 3'd2;
  localparam logic [2:0] REG_PCOUNT   = 3'd3;
  localparam logic [2:0] REG_FAIL_EN  = 3'd4;
  localparam logic [2:0] REG_FAIL_STR = 3'd5;

  localparam logic [47:0] STRESS_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] STRESS_NEG_MAG = 48'h8000_0000_0000;
  localparam logic [63:0] MASK48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] CAP63  = 64'h8000_0000_0000_0000;

  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 64;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);
  localparam int DIV_N_W   = 80;
  localparam int DIV_D_W   = 33;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam logic [1:0] SH_24 = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_40 = 2'd2;

  localparam logic CAP_SEL_48 = 1'b0;
  localparam logic CAP_SEL_63 = 1'b1;

  typedef struct packed {
    logic               command;
    logic [2:0]         point_index;
    logic [30:0]        point_strain;
    logic [46:0]        point_stress;
    logic signed [31:0] strain;
    logic signed [31:0] transverse_strain_sum;
    logic               force_linear;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] stress_out;
    logic [47:0]        tangent_modulus;
    logic               failed;
  } out_item_t;

  // Search wave handed from cell to cell.
  typedef struct packed {
    logic        valid;
    logic        done;
    logic        first_hit;
    logic [30:0] prev_strain;
    logic [46:0] prev_stress;
    logic [30:0] lo_strain;
    logic [46:0] lo_stress;
    logic [30:0] hi_strain;
    logic [46:0] hi_stress;
  } wave_t;

  function automatic logic signed [47:0] sat_stress(input logic [47:0] mag, input logic neg);
    logic [47:0] m;
    begin
      if (neg) begin
        m = (mag > STRESS_NEG_MAG) ? STRESS_NEG_MAG : mag;
        sat_stress = $signed(-m);
      end else begin
        m = (mag > STRESS_POS_MAX) ? STRESS_POS_MAX : mag;
        sat_stress = $signed(m);
      end
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/psse_cell.sv]
// One table point cell: holds a point and advances the segment search wave.
`default_nettype none
module psse_cell #(
  parameter int IDX   = 1,
  parameter int IDX_W = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [2:0]           wr_idx,
  input  wire logic [30:0]          wr_strain,
  input  wire logic [46:0]          wr_stress,
  input  wire logic signed [31:0]   eval_strain,
  input  wire logic [IDX_W-1:0]     last_idx,
  input  wire psse_pkg::wave_t      wave_i,
  output psse_pkg::wave_t           wave_o
);

  logic [30:0]     pt_strain_r;
  logic [46:0]     pt_stress_r;
  psse_pkg::wave_t wave_r, wave_nxt;
  logic            le;

  assign le = eval_strain <= $signed({1'b0, pt_strain_r});

  always_comb begin
    wave_nxt = wave_i;
    wave_nxt.prev_strain = pt_strain_r;
    wave_nxt.prev_stress = pt_stress_r;
    if (wave_i.valid && !wave_i.done) begin
      if ((IDX_W'(IDX) == last_idx) || le) begin
        wave_nxt.done      = 1'b1;
        wave_nxt.lo_strain = wave_i.prev_strain;
        wave_nxt.lo_stress = wave_i.prev_stress;
        wave_nxt.hi_strain = pt_strain_r;
        wave_nxt.hi_stress = pt_stress_r;
        wave_nxt.first_hit = (IDX == 1) && le;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_strain_r <= '0;
      pt_stress_r <= '0;
      wave_r      <= '0;
    end else begin
      wave_r <= wave_nxt;
      if (wr_en && (32'(wr_idx) == IDX)) begin
        pt_strain_r <= wr_strain;
        pt_stress_r <= wr_stress;
      end
    end
  end

  assign wave_o = wave_r;

endmodule
`default_nettype wire

[rtl/core/psse_div.sv]
// Restoring divider, one quotient bit per cycle, saturated quotient.
`default_nettype none
module psse_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [psse_pkg::DIV_N_W-1:0]  num,
  input  wire logic [psse_pkg::DIV_D_W-1:0]  den,
  input  wire logic                          cap_wide,
  output logic                               done,
  output logic [63:0]                        quo
);

  localparam int NW = psse_pkg::DIV_N_W;
  localparam int DW = psse_pkg::DIV_D_W;
  localparam int CW = psse_pkg::DIV_CNT_W;

  logic          busy_r, fin_r, done_r, cap_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r, den_r;
  logic [NW-1:0] q_r;
  logic [63:0]   res_r;
  logic [DW:0]   shifted, diff;
  logic          ge;

  assign shifted = {rem_r, q_r[NW-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        q_r    <= num;
        den_r  <= den;
        cap_r  <= cap_wide;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        if (cap_r == psse_pkg::CAP_SEL_63) begin
          res_r <= (|q_r[NW-1:63]) ? psse_pkg::CAP63 : q_r[63:0];
        end else begin
          res_r <= (|q_r[NW-1:48]) ? psse_pkg::MASK48 : {16'b0, q_r[47:0]};
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = res_r;

endmodule
`default_nettype wire

[rtl/core/psse_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle, shifted and capped result.
`default_nettype none
module psse_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [psse_pkg::MUL_A_W-1:0]  a,
  input  wire logic [psse_pkg::MUL_B_W-1:0]  b,
  input  wire logic [1:0]                    sh,
  output logic                               done,
  output logic [47:0]                        res
);

  localparam int AW = psse_pkg::MUL_A_W;
  localparam int BW = psse_pkg::MUL_B_W;
  localparam int CW = psse_pkg::MUL_CNT_W;

  logic             busy_r, fin_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [AW-1:0]    a_r, hi_r;
  logic [BW-1:0]    lo_r;
  logic [1:0]       sh_r;
  logic [47:0]      res_r;
  logic [AW:0]      sum;
  logic [AW+BW-1:0] prod, shifted;
  logic [6:0]       shamt;

  assign sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
  assign prod = {hi_r, lo_r};

  always_comb begin
    case (sh_r)
      psse_pkg::SH_24: shamt = 7'd24;
      psse_pkg::SH_32: shamt = 7'd32;
      psse_pkg::SH_40: shamt = 7'd40;
      default:         shamt = 7'd24;
    endcase
    shifted = prod >> shamt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a;
        hi_r   <= '0;
        lo_r   <= b;
        sh_r   <= sh;
      end else if (busy_r) begin
        hi_r  <= sum[AW:1];
        lo_r  <= {sum[0], lo_r[BW-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(BW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= (shifted > (AW+BW)'(psse_pkg::STRESS_NEG_MAG)) ?
                  psse_pkg::STRESS_NEG_MAG : shifted[47:0];
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

[rtl/core/piecewise_stress_strain_eval_unit.sv]
// Top level of the piecewise-linear stress-strain evaluator.
// Sequence: a load or a failed strain passes through S_DONE into the output register; an
//   evaluation runs the wave search, then divisions and multiplications on the shared units,
//   with S_YDIV and S_GDIV added only when a Poisson ratio is set.
// Throughput: one request at a time; the next is accepted once the output register takes it.
// Reset: synchronous, active low; the table cells clear in the same cycle, no clearing pass.
`default_nettype none
`include "piecewise_stress_strain_eval_unit_assert.svh"
module piecewise_stress_strain_eval_unit #(
  parameter int MAX_POINTS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire psse_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output psse_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [47:0]         cfg_wdata
);

  localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = IDX_W + 1;

  // Sequencer codes.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_ROUTE  = 4'd3;
  localparam logic [3:0] S_SLOPE  = 4'd4;
  localparam logic [3:0] S_TERM   = 4'd5;
  localparam logic [3:0] S_YDIV   = 4'd6;
  localparam logic [3:0] S_GDIV   = 4'd7;
  localparam logic [3:0] S_FMUL   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // Configuration registers.
  logic [47:0] e_r;
  logic [14:0] nu_r;
  logic        lin_r, fe_r;
  logic [3:0]  pc_r;
  logic [30:0] fs_r;

  // Sequencer and working registers.
  logic [3:0]         state_r, state_nxt;
  logic               go_r, go_nxt;
  logic               head_valid_r, head_valid_nxt;
  logic signed [31:0] s_r, t_r;
  logic               force_r;
  logic signed [49:0] p1_r, x_r;
  logic signed [47:0] p2_r;
  logic [32:0]        den_r;
  logic [30:0]        lo_strain_r, hi_strain_r;
  logic [46:0]        lo_stress_r, hi_stress_r;
  logic               first_r;
  logic signed [31:0] d_r;
  logic signed [47:0] ds_r;
  logic signed [32:0] dx_r;
  logic [47:0]        sl_mag_r;
  logic               sl_neg_r;
  logic [63:0]        y_r, g_r;
  logic signed [47:0] bsat_r;
  psse_pkg::out_item_t res_r, res_nxt;
  psse_pkg::out_item_t out_data_r;
  logic                out_valid_r;

  // Accept and load strobes.
  logic in_acc, load_acc, fail_now, lin_path;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && (in_data.command == psse_pkg::CMD_LOAD);
  assign fail_now = fe_r && (in_data.strain > $signed({1'b0, fs_r}));
  assign lin_path = first_r || force_r;

  // Effective point count and index of the last point.
  logic [CNT_W-1:0] cnt_eff;
  logic [IDX_W-1:0] last_idx;
  always_comb begin
    if ({28'b0, pc_r} < 32'd2) begin
      cnt_eff = CNT_W'(2);
    end else if ({28'b0, pc_r} > 32'(MAX_POINTS)) begin
      cnt_eff = CNT_W'(MAX_POINTS);
    end else begin
      cnt_eff = CNT_W'(pc_r);
    end
  end
  assign last_idx = IDX_W'(cnt_eff - 1'b1);

  // Chain of table cells; point 0 is the origin fed in at the head of the wave.
  psse_pkg::wave_t chain [MAX_POINTS];
  psse_pkg::wave_t head;
  psse_pkg::wave_t tail;
  always_comb begin
    head       = '0;
    head.valid = head_valid_r;
  end
  assign chain[0] = head;

  for (genvar gi = 1; gi < MAX_POINTS; gi++) begin : g_cell
    psse_cell #(
      .IDX   (gi),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .wr_en       (load_acc),
      .wr_idx      (in_data.point_index),
      .wr_strain   (in_data.point_strain),
      .wr_stress   (in_data.point_stress),
      .eval_strain (s_r),
      .last_idx    (last_idx),
      .wave_i      (chain[gi-1]),
      .wave_o      (chain[gi])
    );
  end
  assign tail = chain[MAX_POINTS-1];

  // Magnitudes of the working values.
  logic [31:0] s_mag;
  logic [49:0] x_abs;
  logic [47:0] ds_abs;
  logic [32:0] dx_abs;
  logic [47:0] bsat_mag;
  assign s_mag    = s_r[31] ? (~s_r + 32'd1) : s_r;
  assign x_abs    = x_r[49] ? 50'(-x_r) : x_r;
  assign ds_abs   = ds_r[47] ? 48'(-ds_r) : ds_r;
  assign dx_abs   = dx_r[32] ? 33'(-dx_r) : dx_r;
  assign bsat_mag = bsat_r[47] ? 48'(-bsat_r) : bsat_r;

  // Poisson factors: 1-nu, 1-2nu and 1+nu in Q1.16.
  logic [16:0] onem, onem2, onep;
  logic [33:0] den_full;
  assign onem     = 17'h10000 - {2'b0, nu_r};
  assign onem2    = 17'h10000 - {1'b0, nu_r, 1'b0};
  assign onep     = 17'h10000 + {2'b0, nu_r};
  assign den_full = onem2 * onep;

  // Shared arithmetic units.
  logic        mul_start, mul_done, div_start, div_done, div_cap;
  logic [47:0] mul_a, mul_res;
  logic [63:0] mul_b, div_q;
  logic [1:0]  mul_sh;
  logic [79:0] div_num;
  logic [32:0] div_den;
  logic        fmul_neg;

  assign mul_start = go_r && (state_r inside {S_TERM, S_FMUL});
  assign div_start = go_r && (state_r inside {S_SLOPE, S_YDIV, S_GDIV});

  always_comb begin
    mul_a    = e_r;
    mul_b    = {32'b0, s_mag};
    mul_sh   = psse_pkg::SH_24;
    fmul_neg = s_r[31];
    if (state_r == S_TERM) begin
      mul_a = sl_mag_r;
      mul_b = {31'b0, dx_abs};
    end else if (lin_path && (nu_r != '0)) begin
      mul_b    = y_r;
      mul_sh   = psse_pkg::SH_40;
      fmul_neg = x_r[49];
    end else if (!lin_path) begin
      mul_a    = bsat_mag;
      mul_b    = g_r;
      mul_sh   = psse_pkg::SH_32;
      fmul_neg = bsat_r[47] != x_r[49];
    end
  end

  always_comb begin
    case (state_r)
      S_SLOPE: begin
        div_num = {9'b0, ds_abs[46:0], 24'b0};
        div_den = {2'b0, d_r[30:0]};
        div_cap = psse_pkg::CAP_SEL_48;
      end
      S_GDIV: begin
        div_num = {y_r, 16'b0};
        div_den = {1'b0, s_r};
        div_cap = psse_pkg::CAP_SEL_63;
      end
      default: begin
        div_num = {x_abs[47:0], 32'b0};
        div_den = den_r;
        div_cap = psse_pkg::CAP_SEL_63;
      end
    endcase
  end

  psse_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .res   (mul_res)
  );

  psse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .cap_wide (div_cap),
    .done     (div_done),
    .quo      (div_q)
  );

  // Interpolated stress: lower stress plus or minus the slope term, then saturate.
  logic        term_sub;
  logic [48:0] b49, b49_abs;
  logic signed [47:0] b_sat;
  assign term_sub = (sl_neg_r && (sl_mag_r != '0)) != dx_r[32];
  assign b49      = term_sub ? ({2'b0, lo_stress_r} - {1'b0, mul_res})
                             : ({2'b0, lo_stress_r} + {1'b0, mul_res});
  assign b49_abs  = b49[48] ? (~b49 + 49'd1) : b49;
  assign b_sat    = psse_pkg::sat_stress(b49_abs[47:0], b49[48]);

  // Where to go once the slope is known.
  logic [3:0] after_slope;
  always_comb begin
    if (!lin_path) begin
      after_slope = S_TERM;
    end else if (nu_r == '0) begin
      after_slope = S_FMUL;
    end else begin
      after_slope = S_YDIV;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    go_nxt         = 1'b0;
    head_valid_nxt = 1'b0;
    res_nxt        = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          if (in_data.command == psse_pkg::CMD_LOAD) begin
            state_nxt = S_DONE;
          end else if (fail_now) begin
            res_nxt.failed = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            head_valid_nxt = 1'b1;
            state_nxt      = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (tail.valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_ROUTE;
      end
      S_ROUTE: begin
        if (first_r) begin
          res_nxt.tangent_modulus = e_r;
          state_nxt = after_slope;
          go_nxt    = 1'b1;
        end else if (d_r > 32'sd0) begin
          state_nxt = S_SLOPE;
          go_nxt    = 1'b1;
        end else begin
          res_nxt.tangent_modulus = '0;
          state_nxt = after_slope;
          go_nxt    = 1'b1;
        end
      end
      S_SLOPE: begin
        if (div_done) begin
          res_nxt.tangent_modulus = (ds_r[47] && (div_q[47:0] != '0)) ? '0 : div_q[47:0];
          state_nxt = after_slope;
          go_nxt    = 1'b1;
        end
      end
      S_TERM: begin
        if (mul_done) begin
          if (nu_r == '0) begin
            res_nxt.stress_out = b_sat;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_YDIV;
            go_nxt    = 1'b1;
          end
        end
      end
      S_YDIV: begin
        if (div_done) begin
          state_nxt = lin_path ? S_FMUL : S_GDIV;
          go_nxt    = 1'b1;
        end
      end
      S_GDIV: begin
        if (div_done) begin
          state_nxt = S_FMUL;
          go_nxt    = 1'b1;
        end
      end
      S_FMUL: begin
        if (mul_done) begin
          res_nxt.stress_out = psse_pkg::sat_stress(mul_res, fmul_neg);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      go_r         <= 1'b0;
      head_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      e_r          <= '0;
      nu_r         <= '0;
      lin_r        <= 1'b1;
      pc_r         <= 4'd2;
      fe_r         <= 1'b0;
      fs_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      go_r         <= go_nxt;
      head_valid_r <= head_valid_nxt;

      if (cfg_we) begin
        case (cfg_idx)
          psse_pkg::REG_YOUNGS:   e_r  <= cfg_wdata;
          psse_pkg::REG_POISSON:  nu_r <= cfg_wdata[14:0];
          psse_pkg::REG_LINEAR:   lin_r <= cfg_wdata[0];
          psse_pkg::REG_PCOUNT:   pc_r <= cfg_wdata[3:0];
          psse_pkg::REG_FAIL_EN:  fe_r <= cfg_wdata[0];
          psse_pkg::REG_FAIL_STR: fs_r <= cfg_wdata[30:0];
          default: begin
          end
        endcase
      end

      // Advance the output register: drop a taken result, load a finished one.
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r <= res_r;
    end
    if (in_acc) begin
      s_r     <= in_data.strain;
      t_r     <= in_data.transverse_strain_sum;
      force_r <= in_data.force_linear;
    end
    if (state_r == S_SEARCH) begin
      p1_r  <= $signed({1'b0, onem}) * s_r;
      p2_r  <= $signed({1'b0, nu_r}) * t_r;
      den_r <= den_full[32:0];
      if (tail.valid) begin
        lo_strain_r <= tail.lo_strain;
        lo_stress_r <= tail.lo_stress;
        hi_strain_r <= tail.hi_strain;
        hi_stress_r <= tail.hi_stress;
        first_r     <= lin_r || tail.first_hit;
      end
    end
    if (state_r == S_PREP) begin
      x_r  <= p1_r + 50'(p2_r);
      d_r  <= $signed({1'b0, hi_strain_r}) - $signed({1'b0, lo_strain_r});
      ds_r <= $signed({1'b0, hi_stress_r}) - $signed({1'b0, lo_stress_r});
      dx_r <= $signed({s_r[31], s_r}) - $signed({2'b0, lo_strain_r});
    end
    if (state_r == S_ROUTE) begin
      sl_mag_r <= '0;
      sl_neg_r <= 1'b0;
    end
    if (state_r == S_SLOPE && div_done) begin
      sl_mag_r <= div_q[47:0];
      sl_neg_r <= ds_r[47];
    end
    if (state_r == S_TERM && mul_done) begin
      bsat_r <= b_sat;
    end
    if (state_r == S_YDIV && div_done) begin
      y_r <= div_q;
    end
    if (state_r == S_GDIV && div_done) begin
      g_r <= div_q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Both result values are zero.
  logic out_zero;
  assign out_zero = (out_data.stress_out == 48'sd0) && (out_data.tangent_modulus == 48'd0);

  // The search wave leaves the chain only while the sequencer waits for it.
  `PSSE_ASSERT(a_wave_in_search, tail.valid |-> (state_r == S_SEARCH), "wave outside search")
  // The two shared units never finish in the same cycle.
  `PSSE_ASSERT(a_units_exclusive, !(mul_done && div_done), "multiplier and divider collide")
  // A failed result carries zero stress and zero modulus.
  `PSSE_ASSERT(a_failed_zero, (out_valid && out_data.failed) |-> out_zero, "failed result not zero")
  // Reset empties the output register.
  `PSSE_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid, "output valid after reset")

endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench for the piecewise-linear stress-strain evaluator.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int  NPTS       = 8;
  localparam int  HOLD_LEN   = 600;
  localparam int  TAIL_WAIT  = 400;
  localparam longint CYCLE_LIMIT = 4000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  psse_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  psse_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_idx = '0;
  logic [47:0]         cfg_wdata = '0;

  piecewise_stress_strain_eval_unit #(.MAX_POINTS(NPTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow copy of the material registers and the point table.
  logic [47:0] mat_youngs;
  logic [14:0] mat_nu;
  logic        mat_linear;
  logic [3:0]  mat_count;
  logic        mat_fail_en;
  logic [30:0] mat_fail_strain;
  logic [31:0] pt_strain [NPTS];
  logic [47:0] pt_stress [NPTS];

  psse_pkg::out_item_t stress_due[$];
  int          mismatch_count = 0;
  longint      cycle_count = 0;
  bit          calm = 1'b0;     // no idling on either side while set
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers: magnitudes only, truncating, with a ceiling.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] mag64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] mul_shift_cap(input logic [63:0] a, input logic [63:0] b,
                                                input int sh, input logic [63:0] cap);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    return (p > {64'b0, cap}) ? cap : p[63:0];
  endfunction

  function automatic logic [63:0] div_shift_cap(input logic [63:0] num, input logic [63:0] den,
                                                input int k, input logic [63:0] cap);
    logic [127:0] q;
    if (den == 0) return cap;
    q = ({64'b0, num} << k) / {64'b0, den};
    return (q > {64'b0, cap}) ? cap : q[63:0];
  endfunction

  function automatic longint clamp_stress(input logic [63:0] mag, input bit neg);
    logic [63:0] m;
    if (neg) begin
      m = (mag > {16'b0, psse_pkg::STRESS_NEG_MAG}) ? {16'b0, psse_pkg::STRESS_NEG_MAG} : mag;
      return -longint'(m);
    end
    m = (mag > {16'b0, psse_pkg::STRESS_POS_MAX}) ? {16'b0, psse_pkg::STRESS_POS_MAX} : mag;
    return longint'(m);
  endfunction

  // |x|/D in Q.40, where x mixes axial and transverse strain by nu.
  function automatic logic [63:0] volumetric_scale(input longint s, input longint t,
                                                   output bit neg);
    longint nu, x, den;
    nu  = longint'(mat_nu);
    x   = (65536 - nu) * s + nu * t;
    den = (65536 - 2 * nu) * (65536 + nu);
    neg = x < 0;
    return div_shift_cap(mag64(x), 64'(den), 32, psse_pkg::CAP63);
  endfunction

  function automatic longint segment_slope(input int i);
    longint d, ds;
    logic [63:0] m;
    d  = longint'(pt_strain[i]) - longint'(pt_strain[i-1]);
    ds = longint'(pt_stress[i]) - longint'(pt_stress[i-1]);
    if (d <= 0) return 0;
    m = div_shift_cap(mag64(ds), 64'(d), 24, psse_pkg::MASK48);
    return (ds < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Work out the result of one accepted request and update the table on loads.
  function automatic psse_pkg::out_item_t eval_material(input psse_pkg::in_item_t it);
    psse_pkg::out_item_t r;
    longint      s, t, sl, dx, b, stress;
    int          cnt, seg;
    bit          first, neg, xneg;
    logic [63:0] mag, y, g, term, tangent;
    r = '0;
    if (it.command == psse_pkg::CMD_LOAD) begin
      if (it.point_index != 0) begin
        pt_strain[it.point_index] = {1'b0, it.point_strain};
        pt_stress[it.point_index] = {1'b0, it.point_stress};
      end
      return r;
    end
    s = {{32{it.strain[31]}}, it.strain};
    t = {{32{it.transverse_strain_sum[31]}}, it.transverse_strain_sum};
    if (mat_fail_en && s > longint'(mat_fail_strain)) begin
      r.failed = 1'b1;
      return r;
    end
    cnt = int'(mat_count);
    if (cnt < 2) cnt = 2;
    if (cnt > NPTS) cnt = NPTS;
    seg = 1;
    first = (s <= longint'(pt_strain[1])) || mat_linear;
    if (!first) begin
      seg = cnt - 1;
      for (int i = 2; i < cnt - 1; i++) begin
        if (s <= longint'(pt_strain[i])) begin
          seg = i;
          break;
        end
      end
    end
    if (first) begin
      tangent = {16'b0, mat_youngs};
    end else begin
      sl = segment_slope(seg);
      tangent = (sl < 0) ? 64'd0 : 64'(sl);
    end
    if (first || it.force_linear) begin
      if (mat_nu == 0) begin
        mag = mul_shift_cap({16'b0, mat_youngs}, mag64(s), 24,
                            {16'b0, psse_pkg::STRESS_NEG_MAG});
        neg = s < 0;
      end else begin
        y   = volumetric_scale(s, t, neg);
        mag = mul_shift_cap({16'b0, mat_youngs}, y, 40, {16'b0, psse_pkg::STRESS_NEG_MAG});
      end
      stress = clamp_stress(mag, neg);
    end else begin
      sl   = segment_slope(seg);
      dx   = s - longint'(pt_strain[seg-1]);
      term = mul_shift_cap(mag64(sl), mag64(dx), 24, {16'b0, psse_pkg::STRESS_NEG_MAG});
      b    = longint'(pt_stress[seg-1]);
      b    = ((sl < 0) != (dx < 0)) ? b - longint'(term) : b + longint'(term);
      b    = clamp_stress(mag64(b), b < 0);
      if (mat_nu == 0) begin
        stress = b;
      end else begin
        y      = volumetric_scale(s, t, xneg);
        g      = div_shift_cap(y, 64'(s), 16, psse_pkg::CAP63);
        mag    = mul_shift_cap(mag64(b), g, 32, {16'b0, psse_pkg::STRESS_NEG_MAG});
        stress = clamp_stress(mag, (b < 0) != xneg);
      end
    end
    r.stress_out      = stress[47:0];
    r.tangent_modulus = tangent[47:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request construction and driving
  // ---------------------------------------------------------------------------
  function automatic psse_pkg::in_item_t eval_req(input longint s, input longint t,
                                                  input bit fl);
    psse_pkg::in_item_t it;
    it = '0;
    it.command = psse_pkg::CMD_EVAL;
    it.strain = s[31:0];
    it.transverse_strain_sum = t[31:0];
    it.force_linear = fl;
    // Fill the unused load fields with noise; the block must ignore them.
    it.point_index  = 3'($urandom);
    it.point_strain = 31'($urandom);
    it.point_stress = {15'($urandom), 32'($urandom)};
    return it;
  endfunction

  function automatic psse_pkg::in_item_t load_req(input int idx, input longint st,
                                                  input longint ss);
    psse_pkg::in_item_t it;
    it = '0;
    it.command = psse_pkg::CMD_LOAD;
    it.point_index  = 3'(idx);
    it.point_strain = st[30:0];
    it.point_stress = ss[46:0];
    it.strain = 32'($urandom);
    it.transverse_strain_sum = 32'($urandom);
    it.force_linear = 1'($urandom);
    return it;
  endfunction

  // Offer one request from a falling edge; predict on acceptance; return at a falling edge.
  task automatic send_item(input psse_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    stress_due = {stress_due, eval_material(it)};
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Let every outstanding request drain before touching a register.
  task automatic drain;
    while (stress_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    drain();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      psse_pkg::REG_YOUNGS:   mat_youngs      = val;
      psse_pkg::REG_POISSON:  mat_nu          = val[14:0];
      psse_pkg::REG_LINEAR:   mat_linear      = val[0];
      psse_pkg::REG_PCOUNT:   mat_count       = val[3:0];
      psse_pkg::REG_FAIL_EN:  mat_fail_en     = val[0];
      psse_pkg::REG_FAIL_STR: mat_fail_strain = val[30:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall at random, hold off on request, check every accepted result.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall = (hold_left > 0) || (!calm && $urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    psse_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (stress_due.size() == 0) begin
        $error("unexpected result: stress_out %0d", $signed(out_data.stress_out));
        mismatch_count++;
      end else begin
        want = stress_due.pop_front();
        if (out_data.stress_out !== want.stress_out) begin
          $error("stress_out expected %0d actual %0d",
                 $signed(want.stress_out), $signed(out_data.stress_out));
          mismatch_count++;
        end
        if (out_data.tangent_modulus !== want.tangent_modulus) begin
          $error("tangent_modulus expected %0d actual %0d",
                 want.tangent_modulus, out_data.tangent_modulus);
          mismatch_count++;
        end
        if (out_data.failed !== want.failed) begin
          $error("failed expected %0d actual %0d", want.failed, out_data.failed);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: drop the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: zero modulus, linear mode, so every evaluation gives zero.
  task automatic test_reset_state;
    send_item(eval_req(64'sh7FFF_FFFF, 0, 1'b0));
    send_item(eval_req(-64'sh8000_0000, 64'sh7FFF_FFFF, 1'b1));
  endtask

  // Linear path: largest modulus without the Poisson term, then a small modulus with it.
  task automatic test_linear_path;
    write_reg(psse_pkg::REG_YOUNGS, 48'hFFFF_FFFF_FFFF);
    send_item(eval_req(64'sh7FFF_FFFF, 0, 1'b0));
    send_item(eval_req(-64'sh8000_0000, 0, 1'b0));
    send_item(eval_req(1, -1, 1'b1));
    write_reg(psse_pkg::REG_YOUNGS, 48'd200 << 8);
    write_reg(psse_pkg::REG_POISSON, 48'h7FFF);
    send_item(eval_req(64'sh0100_0000, -64'sh8000_0000, 1'b0));
    send_item(eval_req(-1, 64'sh7FFF_FFFF, 1'b0));
  endtask

  // Table path: origin untouched, degenerate and falling segments, the last point, forced linear, Poisson.
  task automatic test_table_path;
    write_reg(psse_pkg::REG_POISSON, 48'd0);
    write_reg(psse_pkg::REG_LINEAR, 48'd0);
    write_reg(psse_pkg::REG_PCOUNT, 48'd5);
    send_item(load_req(0, 64'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF));
    send_item(load_req(1, 64'h0100_0000, 64'd1000 << 8));
    send_item(load_req(2, 64'h0100_0000, 64'd2000 << 8));
    send_item(load_req(3, 64'h0300_0000, 64'd500 << 8));
    send_item(load_req(4, 64'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF));
    send_item(eval_req(64'h0100_0000, 0, 1'b0));
    send_item(eval_req(64'h0200_0000, 0, 1'b0));
    send_item(eval_req(64'h7FFF_FFFF, 0, 1'b0));
    send_item(eval_req(64'h0280_0000, 0, 1'b1));
    write_reg(psse_pkg::REG_POISSON, 48'd21000);
    send_item(eval_req(64'h0200_0000, -64'h0040_0000, 1'b0));
  endtask

  // Point count below two and above the table size.
  task automatic test_count_limits;
    write_reg(psse_pkg::REG_POISSON, 48'd0);
    write_reg(psse_pkg::REG_PCOUNT, 48'd0);
    send_item(eval_req(64'h0500_0000, 0, 1'b0));
    write_reg(psse_pkg::REG_PCOUNT, 48'd15);
    send_item(eval_req(64'h0500_0000, 0, 1'b0));
  endtask

  // Failure check at both ends of the failure strain.
  task automatic test_failure;
    write_reg(psse_pkg::REG_FAIL_EN, 48'd1);
    write_reg(psse_pkg::REG_FAIL_STR, 48'd0);
    send_item(eval_req(1, 0, 1'b0));
    send_item(eval_req(0, 0, 1'b0));
    write_reg(psse_pkg::REG_FAIL_STR, 48'h7FFF_FFFF);
    send_item(eval_req(64'h7FFF_FFFF, 0, 1'b0));
    write_reg(psse_pkg::REG_FAIL_EN, 48'd0);
  endtask

  // Hold the result side off for a long stretch while requests keep coming.
  task automatic test_backpressure;
    calm = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_item(eval_req(longint'($urandom_range(32'h0800_0000)), 0, 1'($urandom)));
    calm = 1'b0;
  endtask

  function automatic logic [47:0] pick_modulus();
    case ($urandom_range(4))
      0: return 48'hFFFF_FFFF_FFFF;
      1: return {16'($urandom), 32'($urandom)};
      2: return 48'($urandom_range(32'h00FF_FFFF));
      default: return 48'($urandom_range(5000)) << 8;
    endcase
  endfunction

  function automatic longint pick_strain;
    longint top;
    top = longint'(pt_strain[NPTS-1]) + 64'h0100_0000;
    case ($urandom_range(9))
      0, 1, 2: return longint'($urandom_range(top > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(top)));
      3, 4:    return longint'(pt_strain[$urandom_range(NPTS-1)]) + $signed(8'($urandom));
      5:       return -longint'($urandom_range(32'h0400_0000));
      6:       return longint'(mat_fail_strain) + $signed(4'($urandom));
      default: return longint'($signed(32'($urandom)));
    endcase
  endfunction

  // Fill the table: mostly rising curves, sometimes flat or falling steps, sometimes noise.
  task automatic load_curve;
    longint st, ss;
    int     kind;
    kind = $urandom_range(9);
    st = 0;
    ss = 0;
    for (int i = 1; i < NPTS; i++) begin
      if (kind == 0) begin
        st = longint'(31'($urandom));
        ss = longint'({15'($urandom), 32'($urandom)});
      end else begin
        st += (kind == 1 && $urandom_range(3) == 0) ? 0 : $urandom_range(32'h0100_0000, 1);
        if (kind == 2 && $urandom_range(2) == 0) ss -= $urandom_range(32'h00FF_FFFF);
        else ss += longint'($urandom_range(32'hFFFF_FFFF)) << $urandom_range(12);
        if (ss < 0) ss = 0;
        if (ss > 64'h7FFF_FFFF_FFFF) ss = 64'h7FFF_FFFF_FFFF;
      end
      send_item(load_req(i, st, ss));
    end
  endtask

  // Random phases: fresh settings, a fresh curve, then a mixed stream of requests.
  task automatic test_random_phases;
    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 5 || ph == 6);
      if (ph == 0) begin
        write_reg(psse_pkg::REG_YOUNGS, 48'hFFFF_FFFF_FFFF);
        write_reg(psse_pkg::REG_POISSON, 48'h7FFF);
        write_reg(psse_pkg::REG_PCOUNT, 48'd15);
        write_reg(psse_pkg::REG_FAIL_STR, 48'h7FFF_FFFF);
      end else if (ph == 1) begin
        write_reg(psse_pkg::REG_YOUNGS, 48'd0);
        write_reg(psse_pkg::REG_POISSON, 48'd0);
        write_reg(psse_pkg::REG_PCOUNT, 48'd0);
        write_reg(psse_pkg::REG_FAIL_STR, 48'd0);
      end else begin
        write_reg(psse_pkg::REG_YOUNGS, pick_modulus());
        write_reg(psse_pkg::REG_POISSON,
                  ($urandom_range(2) == 0) ? 48'd0 : 48'(15'($urandom)));
        write_reg(psse_pkg::REG_PCOUNT, 48'($urandom_range(9)));
        write_reg(psse_pkg::REG_FAIL_STR, 48'($urandom_range(32'h0800_0000)));
      end
      write_reg(psse_pkg::REG_LINEAR, ($urandom_range(3) == 0) ? 48'd1 : 48'd0);
      write_reg(psse_pkg::REG_FAIL_EN, ($urandom_range(3) == 0) ? 48'd1 : 48'd0);
      load_curve();
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(9) == 0)
          send_item(load_req($urandom_range(NPTS-1), longint'(31'($urandom)),
                             longint'({15'($urandom), 32'($urandom)})));
        else
          send_item(eval_req(pick_strain(), longint'($signed(32'($urandom))) >>>
                             $urandom_range(8), ($urandom_range(4) == 0)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    mat_youngs = '0; mat_nu = '0; mat_linear = 1'b1; mat_count = 4'd2;
    mat_fail_en = 1'b0; mat_fail_strain = '0;
    for (int i = 0; i < NPTS; i++) begin
      pt_strain[i] = '0;
      pt_stress[i] = '0;
    end
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_state();
    test_linear_path();
    test_table_path();
    test_count_limits();
    test_failure();
    test_backpressure();
    test_random_phases();
    // Wait for the last results, then give the block a little longer to misbehave.
    while (stress_due.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);
    if (mismatch_count == 0 && stress_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[piecewise_stress_strain_eval_unit.f]
+incdir+rtl/core
rtl/core/psse_pkg.sv
rtl/core/psse_cell.sv
rtl/core/psse_div.sv
rtl/core/psse_mul.sv
rtl/core/piecewise_stress_strain_eval_unit.sv
bench/tb.sv
